[rtl/modular_arithmetic_unit_defines.svh]
// Assertion macros shared by the RTL files
`ifndef MODULAR_ARITHMETIC_UNIT_DEFINES_SVH
`define MODULAR_ARITHMETIC_UNIT_DEFINES_SVH

// a implies b on the next clock edge
`define MAU_ASSERT_NEXT(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

// a implies b on the same clock edge
`define MAU_ASSERT_SAME(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

`endif

[rtl/mau_pkg.sv]
package mau_pkg;

   localparam int unsigned DefaultWidth = 16;
   localparam int unsigned CsrIndexWidth = 1;

   localparam logic [2:0] FUNC_REDUCE  = 3'd0;
   localparam logic [2:0] FUNC_ADD     = 3'd1;
   localparam logic [2:0] FUNC_NEGATE  = 3'd2;
   localparam logic [2:0] FUNC_MUL     = 3'd3;
   localparam logic [2:0] FUNC_INVERSE = 3'd4;
   localparam logic [2:0] FUNC_COMPARE = 3'd5;
   localparam logic [2:0] FUNC_NONE    = 3'd7;

   localparam logic [CsrIndexWidth-1:0] CSR_MODULUS = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_PRIME   = 1'd1;

   typedef struct packed {
      logic [2:0]              func;
      logic [DefaultWidth-1:0] operand_a;
      logic [DefaultWidth-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [DefaultWidth-1:0] result;
      logic                    is_equal;
      logic                    error;
   } rsp_type;

endpackage

[rtl/mau_front.sv]
// Accepts a request and pushes it into a two-entry queue for the back end.
module mau_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_start,
   input  mau_pkg::req_type  req_data,
   output logic              req_busy,
   input  logic              pop,
   output logic              q_valid,
   output mau_pkg::req_type  q_data
);
   import mau_pkg::*;
   `include "modular_arithmetic_unit_defines.svh"

   req_type     mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   req_type     clean;

   always_comb begin
      clean = req_data;
      // unused codes do nothing; fold them to a harmless function with zeroed result
      if (req_data.func > FUNC_COMPARE) begin
         clean.func = FUNC_NONE;
      end
   end

   assign req_busy = (count_ff == 2'd2);
   assign push     = req_start && !req_busy;
   assign q_valid  = (count_ff != 2'd0);
   assign q_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ (pop && q_valid);
      count_in  = count_ff + {1'b0, push} - {1'b0, pop && q_valid};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= clean;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `MAU_ASSERT_SAME(a_count_range, clock, reset, 1'b1, count_ff != 2'd3, "queue overflow")
   `MAU_ASSERT_NEXT(a_push_grows, clock, reset, push && !pop, count_ff != 2'd0,
      "push lost")
   `MAU_ASSERT_SAME(a_ptr_match, clock, reset, count_ff == 2'd0 || count_ff == 2'd2,
      wr_ptr_ff == rd_ptr_ff, "pointer mismatch")
endmodule

[rtl/mau_back.sv]
// Sequential executor: restoring remainder unit shared by reduction,
// multiply (shift-add with reduction), and extended Euclid.
module mau_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [mau_pkg::DefaultWidth-1:0]  modulus,
   input  logic                              modulus_is_prime,
   input  logic                              q_valid,
   input  mau_pkg::req_type                  q_data,
   output logic                              pop,
   output logic                              rsp_valid,
   output mau_pkg::rsp_type                  rsp_data
);
   import mau_pkg::*;
   `include "modular_arithmetic_unit_defines.svh"

   localparam int unsigned WIDTH = DefaultWidth;
   localparam int unsigned CW = $clog2(WIDTH + 1);
   localparam logic [3:0] S_IDLE = 4'd0, S_REDA = 4'd1, S_REDB = 4'd2, S_OP = 4'd3,
      S_MUL = 4'd4, S_DIV = 4'd5, S_UPD = 4'd6, S_FIX = 4'd7, S_DONE = 4'd8;

   logic [3:0]        state_ff, state_in;
   logic [2:0]        func_ff, func_in;
   logic [WIDTH-1:0]  n_ff, n_in, a_ff, a_in, b_ff, b_in;
   logic [WIDTH-1:0]  x_ff, x_in;          // dividend bits / multiplier
   logic [WIDTH-1:0]  rem_ff, rem_in, quo_ff, quo_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [WIDTH-1:0]  r0_ff, r0_in, r1_ff, r1_in;
   logic [WIDTH:0]    s0_ff, s0_in, s1_ff, s1_in; // kept mod n, s < n
   logic [WIDTH-1:0]  res_ff, res_in;
   logic              eq_ff, eq_in, err_ff, err_in, vld_ff, vld_in;

   logic [WIDTH:0]    trial, sum, dbl, dbl_red, qs_add;
   logic [WIDTH-1:0]  eff_n;

   assign eff_n = (modulus < WIDTH'(2)) ? WIDTH'(1) : modulus;

   always_comb begin
      // one restoring division step: shift in top bit of x
      trial = {rem_ff, x_ff[WIDTH-1]} - {1'b0, n_ff};
      sum   = {1'b0, a_ff} + {1'b0, b_ff};
      dbl   = {rem_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, n_ff}) ? dbl - {1'b0, n_ff} : dbl;
      qs_add  = dbl_red + (x_ff[WIDTH-1] ? {1'b0, a_ff} : '0);
   end

   always_comb begin
      state_in = state_ff; func_in = func_ff; n_in = n_ff; a_in = a_ff; b_in = b_ff;
      x_in = x_ff; rem_in = rem_ff; quo_in = quo_ff; cnt_in = cnt_ff;
      r0_in = r0_ff; r1_in = r1_ff; s0_in = s0_ff; s1_in = s1_ff;
      res_in = res_ff; eq_in = eq_ff; err_in = err_ff; vld_in = 1'b0; pop = 1'b0;
      unique case (state_ff) inside
         S_IDLE: begin
            if (q_valid) begin
               pop = 1'b1;
               func_in = q_data.func;
               n_in = eff_n;
               x_in = q_data.operand_a[WIDTH-1:0];
               b_in = q_data.operand_b[WIDTH-1:0];
               rem_in = '0; cnt_in = CW'(WIDTH);
               res_in = '0; eq_in = 1'b0; err_in = 1'b0;
               state_in = S_REDA;
            end
         end
         S_REDA, S_REDB, S_DIV: begin
            if (!trial[WIDTH]) begin
               rem_in = trial[WIDTH-1:0];
            end else begin
               rem_in = {rem_ff[WIDTH-2:0], x_ff[WIDTH-1]};
            end
            quo_in = {quo_ff[WIDTH-2:0], !trial[WIDTH]};
            x_in = {x_ff[WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               if (state_ff == S_REDA) begin
                  a_in = rem_in; x_in = b_ff; rem_in = '0; cnt_in = CW'(WIDTH);
                  state_in = S_REDB;
               end else if (state_ff == S_REDB) begin
                  b_in = rem_in;
                  state_in = S_OP;
               end else begin
                  // r1 stays divisor; remainder and quotient ready
                  state_in = S_UPD;
               end
            end
         end
         S_OP: begin
            state_in = S_DONE;
            case (func_ff)
               FUNC_REDUCE: res_in = a_ff;
               FUNC_ADD: res_in = (sum >= {1'b0, n_ff}) ?
                  WIDTH'(sum - {1'b0, n_ff}) : sum[WIDTH-1:0];
               FUNC_NEGATE: res_in = (a_ff == '0) ? '0 : n_ff - a_ff;
               FUNC_MUL: begin
                  x_in = a_ff; a_in = b_ff; rem_in = '0; cnt_in = CW'(WIDTH);
                  state_in = S_MUL;
               end
               FUNC_INVERSE: begin
                  if (!modulus_is_prime || a_ff == '0) begin
                     err_in = 1'b1;
                  end else begin
                     r0_in = n_ff; r1_in = a_ff; s0_in = '0; s1_in = (WIDTH+1)'(1);
                     state_in = S_FIX;
                  end
               end
               FUNC_COMPARE: eq_in = (a_ff == b_ff);
               default: ;
            endcase
         end
         S_MUL: begin
            // Horner: rem = 2*rem + bit*a, kept below n
            rem_in = (qs_add >= {1'b0, n_ff}) ?
               WIDTH'(qs_add - {1'b0, n_ff}) : qs_add[WIDTH-1:0];
            x_in = {x_ff[WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               res_in = rem_in;
               state_in = S_DONE;
            end
         end
         S_FIX: begin
            // loop head: r1 == 0 ends, else divide r0 by r1
            if (r1_ff == '0) begin
               if (r0_ff == WIDTH'(1)) res_in = s0_ff[WIDTH-1:0];
               else err_in = 1'b1;
               state_in = S_DONE;
            end else begin
               n_in = r1_ff; x_in = r0_ff; rem_in = '0; quo_in = '0;
               cnt_in = CW'(WIDTH); state_in = S_DIV;
            end
         end
         S_UPD: begin
            // s_new = s0 - q*s1 mod modulus, via Horner on q bits
            if (cnt_ff == '0) begin
               r0_in = r1_ff; r1_in = rem_ff; cnt_in = CW'(WIDTH);
               a_in = s1_ff[WIDTH-1:0]; x_in = quo_ff; rem_in = '0;
               n_in = eff_n;
               state_in = S_MUL;
               func_in = FUNC_INVERSE;
            end
            state_in = S_UPD;
            cnt_in = cnt_ff;
         end
         S_DONE: begin
            vld_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Euclid bookkeeping lives in a small helper sequence below to keep S_MUL shared
   logic [1:0]        eu_ff, eu_in;
   localparam logic [1:0] EU_NONE = 2'd0, EU_MUL = 2'd1;

   logic [3:0]       st_fin;
   logic [WIDTH-1:0] n_fin, a_fin, x_fin, rem_fin, res_fin, r0_fin, r1_fin;
   logic [WIDTH:0]   s0_fin, s1_fin;
   logic [CW-1:0]    cnt_fin;

   always_comb begin
      st_fin = state_in; n_fin = n_in; a_fin = a_in; x_fin = x_in; rem_fin = rem_in;
      res_fin = res_in; r0_fin = r0_in; r1_fin = r1_in; s0_fin = s0_in; s1_fin = s1_in;
      cnt_fin = cnt_in; eu_in = eu_ff;
      if (state_ff == S_UPD) begin
         r0_fin = r1_ff; r1_fin = rem_ff; n_fin = eff_n; a_fin = s1_ff[WIDTH-1:0];
         x_fin = quo_ff; rem_fin = '0; cnt_fin = CW'(WIDTH); st_fin = S_MUL;
         eu_in = EU_MUL;
      end else if (state_ff == S_MUL && eu_ff == EU_MUL && cnt_ff == CW'(1)) begin
         // rem_in = q*s1 mod n; s_new = s0 - that
         s1_fin = (s0_ff >= {1'b0, rem_in}) ? s0_ff - {1'b0, rem_in}
                : s0_ff + {1'b0, n_ff} - {1'b0, rem_in};
         s0_fin = s1_ff;
         res_fin = res_ff;
         st_fin = S_FIX; eu_in = EU_NONE;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in; n_ff <= n_fin; a_ff <= a_fin; b_ff <= b_in; x_ff <= x_fin;
      rem_ff <= rem_fin; quo_ff <= quo_in; cnt_ff <= cnt_fin; r0_ff <= r0_fin;
      r1_ff <= r1_fin; s0_ff <= s0_fin; s1_ff <= s1_fin; res_ff <= res_fin;
      eq_ff <= eq_in; err_ff <= err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; vld_ff <= 1'b0; eu_ff <= EU_NONE;
      end else begin
         state_ff <= st_fin; vld_ff <= vld_in; eu_ff <= eu_in;
      end
   end

   assign rsp_valid = vld_ff;
   always_comb begin
      rsp_data = '0;
      rsp_data.result   = res_ff;
      rsp_data.is_equal = eq_ff;
      rsp_data.error    = err_ff;
   end

   `MAU_ASSERT_NEXT(a_done_valid, clock, reset, state_ff == S_DONE, rsp_valid,
      "result not issued")
   `MAU_ASSERT_SAME(a_err_zero, clock, reset, rsp_valid && rsp_data.error,
      rsp_data.result == '0, "error with nonzero result")
   `MAU_ASSERT_SAME(a_pop_idle, clock, reset, pop, state_ff == S_IDLE,
      "pop while busy")
   `MAU_ASSERT_SAME(a_eq_no_err, clock, reset, rsp_valid,
      !(rsp_data.is_equal && rsp_data.error), "flags both set")
endmodule

[rtl/modular_arithmetic_unit.sv]
// Sequence per item, from start transfer to rsp_valid: both operands are reduced,
// then the operation runs; multiply adds a Horner pass. Inverse repeats a division
// and a multiply-based update per Euclid step (up to ~24 steps).
// Throughput: one item at a time in the back end, set by the shared bit-serial
// remainder unit; a two-entry queue lets start be taken while it works.
// Reset (synchronous, active high): modulus 2, prime flag 1, queue empty.
// The receiver cannot stall: rsp_valid pulses for one cycle per item.
module modular_arithmetic_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  mau_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   output mau_pkg::rsp_type                    rsp_data,
   input  logic                                csr_write,
   input  logic [mau_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [mau_pkg::DefaultWidth-1:0]    csr_data
);
   import mau_pkg::*;

   localparam int unsigned WIDTH = DefaultWidth;

   logic [WIDTH-1:0] modulus_ff;
   logic             prime_ff;
   logic             pop, q_valid;
   req_type          q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= WIDTH'(2);
         prime_ff   <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MODULUS: modulus_ff <= csr_data[WIDTH-1:0];
            CSR_PRIME:   prime_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   mau_front u_front (
      .clock, .reset, .req_start(start), .req_data, .req_busy(busy),
      .pop, .q_valid, .q_data
   );

   mau_back u_back (
      .clock, .reset, .modulus(modulus_ff), .modulus_is_prime(prime_ff),
      .q_valid, .q_data, .pop, .rsp_valid, .rsp_data
   );
endmodule
